[src/alc_lct_header_parser_assert.svh]
// ----------------------------------------------------------------------------
// ALC/LCT header parser assertion macros
// Concurrent check helpers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ALC_LCT_HEADER_PARSER_ASSERT_SVH
`define ALC_LCT_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define ALC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ALC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ALC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define ALC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[src/alc_lct_pkg.sv]
// ----------------------------------------------------------------------------
// ALC/LCT header parser package
// Error codes, extension types and header helper functions.
// ----------------------------------------------------------------------------
package alc_lct_pkg;

   typedef enum logic [3:0] {
      ERR_OK        = 4'd0,
      ERR_SHORT     = 4'd1,
      ERR_VERSION   = 4'd2,
      ERR_LEN_FLAGS = 4'd3,
      ERR_LEN_PKT   = 4'd4,
      ERR_CCI       = 4'd5,
      ERR_NO_TSI    = 4'd6,
      ERR_NO_TOI    = 4'd7,
      ERR_TOI_WIDE  = 4'd8,
      ERR_CODEPOINT = 4'd9,
      ERR_EXT_ZERO  = 4'd10,
      ERR_EXT_OVER  = 4'd11,
      ERR_FTI_LEN   = 4'd12,
      ERR_FDT_VER   = 4'd13,
      ERR_ENCODING  = 4'd14
   } err_code_type;

   localparam logic [7:0]  EXT_FTI         = 8'd64;
   localparam logic [7:0]  EXT_FDT         = 8'd192;
   localparam logic [7:0]  EXT_CONTENT_ENC = 8'd193;
   localparam logic [7:0]  EXT_HEL_MAX     = 8'd127;
   localparam logic [10:0] COUNT_MAX       = 11'd2047;
   localparam logic [3:0]  CSR_VERSION     = 4'd0;

   // Header length in words implied by the flags of the base word
   function automatic logic [4:0] std_words(input logic [31:0] bw, input logic [3:0] ver);
      logic [4:0] w;
      w = 5'd2 + 5'(bw[27:26]) + 5'(bw[20]) + 5'(bw[23]) + 5'(bw[22:21]);
      if (ver == 4'd1) w = w + 5'(bw[19]) + 5'(bw[18]);
      return w;
   endfunction

endpackage

[src/alc_lct_req_if.sv]
// ----------------------------------------------------------------------------
// ALC/LCT request channel
// One packet byte per request with a last-byte mark.
// ----------------------------------------------------------------------------
interface alc_lct_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

[src/alc_lct_rsp_if.sv]
// ----------------------------------------------------------------------------
// ALC/LCT result channel
// Parsed header fields or an error code, one result per packet.
// ----------------------------------------------------------------------------
interface alc_lct_rsp_if;
   import alc_lct_pkg::*;
   logic         valid;
   logic         ready;
   err_code_type error_code;
   logic [47:0]  session_id;
   logic [63:0]  object_id;
   logic [7:0]   header_words;
   logic         close_session;
   logic         has_fti;
   logic [47:0]  transfer_len;
   logic [15:0]  symbol_length;
   logic [31:0]  max_block_length;
   logic         has_fdt;
   logic [19:0]  fdt_instance;
   logic [1:0]   content_coding;

   modport source (output valid, error_code, session_id, object_id, header_words,
                   close_session, has_fti, transfer_len, symbol_length,
                   max_block_length, has_fdt, fdt_instance, content_coding,
                   input ready);
   modport sink   (input valid, error_code, session_id, object_id, header_words,
                   close_session, has_fti, transfer_len, symbol_length,
                   max_block_length, has_fdt, fdt_instance, content_coding,
                   output ready);
endinterface

[src/alc_lct_header_parser.sv]
// ----------------------------------------------------------------------------
// ALC/LCT header parser
// Byte-wide parser for the LCT base header, TSI/TOI and header extensions.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  req_ch  | in  | valid/ready        | data_byte, last_byte
//  rsp_ch  | out | valid/ready        | error_code .. content_coding
//  csr     | in  | psel/penable/pwrite| version register at address 0
//
// One byte per cycle while req_ch.ready is high; every byte updates the parser
// state in the cycle it is accepted. The request on the last byte loads the
// result register, so the result appears in the cycle after it. A new request
// is taken while a result waits unless that result is stalled by rsp_ch.ready.
// Synchronous reset clears all packet state and sets the version register to 1.
// ----------------------------------------------------------------------------
module alc_lct_header_parser (
   input  logic                clock,
   input  logic                reset,
   alc_lct_req_if.sink         req_ch,
   alc_lct_rsp_if.source       rsp_ch,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [1:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import alc_lct_pkg::*;

`include "alc_lct_header_parser_assert.svh"

   // state
   logic [3:0]   exp_ver_ff, exp_ver_in;
   logic [3:0]   ver_lat_ff, ver_lat_in;
   logic [10:0]  count_ff, count_in;
   logic [31:0]  base_ff, base_in;
   logic [9:0]   left_ff, left_in;
   logic [9:0]   idx_ff, idx_in;
   logic [7:0]   kind_ff, kind_in;
   logic [9:0]   size_ff, size_in;
   logic [47:0]  tsi_ff, tsi_in;
   logic [63:0]  toi_ff, toi_in;
   logic         fti_v_ff, fti_v_in;
   logic [47:0]  xfer_ff, xfer_in;
   logic [15:0]  sym_ff, sym_in;
   logic [31:0]  mblk_ff, mblk_in;
   logic         fdt_v_ff, fdt_v_in;
   logic [19:0]  inst_ff, inst_in;
   logic [1:0]   coding_ff, coding_in;
   err_code_type ferr_ff, ferr_in;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   err_code_type r_err_ff, r_err_in;
   logic [47:0]  r_tsi_ff, r_tsi_in;
   logic [63:0]  r_toi_ff, r_toi_in;
   logic [7:0]   r_hl_ff, r_hl_in;
   logic         r_a_ff, r_a_in;
   logic         r_fti_ff, r_fti_in;
   logic [47:0]  r_xfer_ff, r_xfer_in;
   logic [15:0]  r_sym_ff, r_sym_in;
   logic [31:0]  r_mblk_ff, r_mblk_in;
   logic         r_fdt_ff, r_fdt_in;
   logic [19:0]  r_inst_ff, r_inst_in;
   logic [1:0]   r_cod_ff, r_cod_in;

   // scratch
   logic         req_acc;
   logic [7:0]   b;
   logic [4:0]   stdw;
   logic [7:0]   hl;
   logic [7:0]   hl_diff;
   logic         fh, fs;
   logic [1:0]   fo;
   logic [10:0]  pos_tw, pos_th, pos_ow, k;
   logic [79:0]  tsi_x;
   logic [95:0]  toi_x;
   logic [6:0]   toff;
   logic [5:0]   soff;
   logic [31:0]  cur;
   err_code_type xerr, ferr_fin;
   logic [10:0]  jn;

   // check terms
   logic         last_acc;
   logic         err_out;
   logic         data_zero;
   logic         pkt_idle;

   assign req_acc      = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign b            = req_ch.data_byte;

   // configuration port
   assign pready = 1'b1;
   assign prdata = {28'd0, exp_ver_ff};
   always_comb begin
      exp_ver_in = exp_ver_ff;
      if (psel && penable && pwrite && paddr == 2'(4 * CSR_VERSION)) exp_ver_in = pwdata[3:0];
   end

   // per-byte parsing
   always_comb begin
      ver_lat_in = ver_lat_ff; count_in = count_ff; base_in = base_ff;
      left_in = left_ff; idx_in = idx_ff; kind_in = kind_ff; size_in = size_ff;
      tsi_in = tsi_ff; toi_in = toi_ff; fti_v_in = fti_v_ff; xfer_in = xfer_ff;
      sym_in = sym_ff; mblk_in = mblk_ff; fdt_v_in = fdt_v_ff; inst_in = inst_ff;
      coding_in = coding_ff; ferr_in = ferr_ff;
      stdw = 5'd0; hl = 8'd0; hl_diff = 8'd0;
      fh = base_ff[20]; fs = base_ff[23]; fo = base_ff[22:21];
      pos_tw = 11'd0; pos_th = 11'd0; pos_ow = 11'd0; k = 11'd0;
      tsi_x = 80'd0; toi_x = 96'd0; toff = 7'd0; soff = 6'd0; cur = 32'd0;
      xerr = ERR_OK; ferr_fin = ERR_OK; jn = 11'd0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      r_err_in = r_err_ff; r_tsi_in = r_tsi_ff; r_toi_in = r_toi_ff; r_hl_in = r_hl_ff;
      r_a_in = r_a_ff; r_fti_in = r_fti_ff; r_xfer_in = r_xfer_ff; r_sym_in = r_sym_ff;
      r_mblk_in = r_mblk_ff; r_fdt_in = r_fdt_ff; r_inst_in = r_inst_ff;
      r_cod_in = r_cod_ff;

      if (req_acc) begin
         if (count_ff < 11'd4) begin
            // base word
            base_in = {base_ff[23:0], b};
            if (count_ff == 11'd3) begin
               ver_lat_in = exp_ver_ff;
               stdw       = std_words(base_in, exp_ver_ff);
               hl         = base_in[15:8];
               hl_diff    = hl - 8'(stdw);
               left_in    = (hl >= 8'(stdw)) ? {hl_diff, 2'b00} : 10'd0;
               idx_in     = 10'd0;
            end
         end else begin
            // TSI / TOI
            pos_tw = 11'd8 + (fh ? 11'd2 : 11'd0);
            pos_th = pos_tw + (fs ? 11'd4 : 11'd0);
            pos_ow = pos_th + (fh ? 11'd2 : 11'd0);
            if (fh && count_ff >= 11'd8 && count_ff < 11'd10)
               tsi_in[15:0] = {tsi_ff[7:0], b};
            if (fs && count_ff >= pos_tw && count_ff < pos_tw + 11'd4) begin
               soff  = fh ? 6'd16 : 6'd0;
               tsi_x = {32'd0, tsi_ff};
               cur   = tsi_x[soff +: 32];
               tsi_x[soff +: 32] = {cur[23:0], b};
               tsi_in = tsi_x[47:0];
            end
            if (fh && count_ff >= pos_th && count_ff < pos_th + 11'd2)
               toi_in[15:0] = {toi_ff[7:0], b};
            if ((fo == 2'd1 && count_ff >= pos_ow && count_ff < pos_ow + 11'd4) ||
                (fo == 2'd2 && count_ff >= pos_ow && count_ff < pos_ow + 11'd8)) begin
               k     = count_ff - pos_ow;
               toff  = (fh ? 7'd16 : 7'd0) + (k[2] ? 7'd32 : 7'd0);
               toi_x = {32'd0, toi_ff};
               cur   = toi_x[toff +: 32];
               toi_x[toff +: 32] = {cur[23:0], b};
               toi_in = toi_x[63:0];
            end

            // header extensions
            stdw = std_words(base_ff, ver_lat_ff);
            if (count_ff >= {4'd0, stdw, 2'b00} && left_ff != 10'd0 && ferr_ff == ERR_OK) begin
               if (idx_ff == 10'd0) begin
                  kind_in = b;
                  if (b > EXT_HEL_MAX) begin
                     size_in = 10'd4;
                     if (left_ff < 10'd4) xerr = ERR_EXT_OVER;
                  end else begin
                     size_in = 10'd0;
                  end
               end else if (idx_ff == 10'd1 && kind_ff <= EXT_HEL_MAX) begin
                  size_in = {b, 2'b00};
                  if (b == 8'd0) xerr = ERR_EXT_ZERO;
                  else if ({b, 2'b00} > left_ff) xerr = ERR_EXT_OVER;
                  else if (kind_ff == EXT_FTI) begin
                     if (b != 8'd4) xerr = ERR_FTI_LEN;
                     else fti_v_in = 1'b1;
                  end
               end else if (kind_ff == EXT_FTI) begin
                  if (idx_ff == 10'd2 || idx_ff == 10'd3)
                     xfer_in[47:32] = {xfer_ff[39:32], b};
                  else if (idx_ff >= 10'd4 && idx_ff < 10'd8)
                     xfer_in[31:0] = {xfer_ff[23:0], b};
                  else if (idx_ff == 10'd10 || idx_ff == 10'd11)
                     sym_in = {sym_ff[7:0], b};
                  else if (idx_ff >= 10'd12 && idx_ff < 10'd16)
                     mblk_in = {mblk_ff[23:0], b};
               end else if (kind_ff == EXT_FDT) begin
                  if (idx_ff == 10'd1) begin
                     if (b[7:4] != ver_lat_ff) xerr = ERR_FDT_VER;
                     else begin
                        fdt_v_in = 1'b1;
                        inst_in  = {b[3:0], 16'd0};
                     end
                  end else if (idx_ff == 10'd2) inst_in = {inst_ff[19:16], b, 8'd0};
                  else if (idx_ff == 10'd3) inst_in = {inst_ff[19:8], b};
               end else if (kind_ff == EXT_CONTENT_ENC) begin
                  if (idx_ff == 10'd1) begin
                     if (b > 8'd3) xerr = ERR_ENCODING;
                     else coding_in = b[1:0];
                  end
               end

               // advance through the extension
               if (xerr != ERR_OK) begin
                  ferr_in = xerr;
               end else begin
                  jn      = {1'b0, idx_ff} + 11'd1;
                  left_in = left_ff - 10'd1;
                  if ((kind_in > EXT_HEL_MAX || jn >= 11'd2) && jn >= {1'b0, size_in})
                     jn = 11'd0;
                  idx_in = jn[9:0];
               end
            end
         end
         count_in = (count_ff < COUNT_MAX) ? count_ff + 11'd1 : COUNT_MAX;

         // last byte: checks in order, load result, clear packet state
         if (req_ch.last_byte) begin
            stdw = std_words(base_in, ver_lat_in);
            hl   = base_in[15:8];
            if (count_in < 11'd4) ferr_fin = ERR_SHORT;
            else if (base_in[31:28] != 4'd1) ferr_fin = ERR_VERSION;
            else if (hl < 8'(stdw)) ferr_fin = ERR_LEN_FLAGS;
            else if ({1'b0, hl, 2'b00} > count_in) ferr_fin = ERR_LEN_PKT;
            else if (base_in[27:26] != 2'd0) ferr_fin = ERR_CCI;
            else if (!base_in[20] && !base_in[23]) ferr_fin = ERR_NO_TSI;
            else if (!base_in[17] && !base_in[20] && base_in[22:21] == 2'd0)
               ferr_fin = ERR_NO_TOI;
            else if ((base_in[22:21] == 2'd2 && base_in[20]) || base_in[22:21] == 2'd3)
               ferr_fin = ERR_TOI_WIDE;
            else if (base_in[7:0] != 8'd0) ferr_fin = ERR_CODEPOINT;
            else ferr_fin = ferr_in;

            rsp_valid_in = 1'b1;
            r_err_in  = ferr_fin;
            if (ferr_fin == ERR_OK) begin
               r_tsi_in = tsi_in; r_toi_in = toi_in; r_hl_in = hl; r_a_in = base_in[17];
               r_fti_in = fti_v_in; r_xfer_in = xfer_in; r_sym_in = sym_in;
               r_mblk_in = mblk_in; r_fdt_in = fdt_v_in; r_inst_in = inst_in;
               r_cod_in = coding_in;
            end else begin
               r_tsi_in = '0; r_toi_in = '0; r_hl_in = '0; r_a_in = 1'b0;
               r_fti_in = 1'b0; r_xfer_in = '0; r_sym_in = '0; r_mblk_in = '0;
               r_fdt_in = 1'b0; r_inst_in = '0; r_cod_in = '0;
            end

            ver_lat_in = '0; count_in = '0; base_in = '0; left_in = '0; idx_in = '0;
            kind_in = '0; size_in = '0; tsi_in = '0; toi_in = '0; fti_v_in = 1'b0;
            xfer_in = '0; sym_in = '0; mblk_in = '0; fdt_v_in = 1'b0; inst_in = '0;
            coding_in = '0; ferr_in = ERR_OK;
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ver_ff <= 4'd1; ver_lat_ff <= '0; count_ff <= '0; base_ff <= '0;
         left_ff <= '0; idx_ff <= '0; kind_ff <= '0; size_ff <= '0;
         tsi_ff <= '0; toi_ff <= '0; fti_v_ff <= 1'b0; xfer_ff <= '0; sym_ff <= '0;
         mblk_ff <= '0; fdt_v_ff <= 1'b0; inst_ff <= '0; coding_ff <= '0;
         ferr_ff <= ERR_OK; rsp_valid_ff <= 1'b0;
      end else begin
         exp_ver_ff <= exp_ver_in; ver_lat_ff <= ver_lat_in; count_ff <= count_in;
         base_ff <= base_in; left_ff <= left_in; idx_ff <= idx_in; kind_ff <= kind_in;
         size_ff <= size_in; tsi_ff <= tsi_in; toi_ff <= toi_in; fti_v_ff <= fti_v_in;
         xfer_ff <= xfer_in; sym_ff <= sym_in; mblk_ff <= mblk_in; fdt_v_ff <= fdt_v_in;
         inst_ff <= inst_in; coding_ff <= coding_in; ferr_ff <= ferr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      r_err_ff <= r_err_in; r_tsi_ff <= r_tsi_in; r_toi_ff <= r_toi_in;
      r_hl_ff <= r_hl_in; r_a_ff <= r_a_in; r_fti_ff <= r_fti_in;
      r_xfer_ff <= r_xfer_in; r_sym_ff <= r_sym_in; r_mblk_ff <= r_mblk_in;
      r_fdt_ff <= r_fdt_in; r_inst_ff <= r_inst_in; r_cod_ff <= r_cod_in;
   end

   // result outputs
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.error_code       = r_err_ff;
   assign rsp_ch.session_id       = r_tsi_ff;
   assign rsp_ch.object_id        = r_toi_ff;
   assign rsp_ch.header_words     = r_hl_ff;
   assign rsp_ch.close_session    = r_a_ff;
   assign rsp_ch.has_fti          = r_fti_ff;
   assign rsp_ch.transfer_len     = r_xfer_ff;
   assign rsp_ch.symbol_length    = r_sym_ff;
   assign rsp_ch.max_block_length = r_mblk_ff;
   assign rsp_ch.has_fdt          = r_fdt_ff;
   assign rsp_ch.fdt_instance     = r_inst_ff;
   assign rsp_ch.content_coding   = r_cod_ff;

   // check terms
   assign last_acc  = req_acc && req_ch.last_byte;
   assign err_out   = rsp_valid_ff && r_err_ff != ERR_OK;
   assign data_zero = r_tsi_ff == '0 && r_toi_ff == '0 && !r_fti_ff && !r_fdt_ff &&
                      r_cod_ff == '0;
   assign pkt_idle  = count_ff == '0 && ferr_ff == ERR_OK && left_ff == '0;

   // checks
   `ALC_ASSERT_IMP(a_err_clean, clock, reset, err_out, data_zero, "error result carries data")
   `ALC_ASSERT_NXT(a_last_clears, clock, reset, last_acc, pkt_idle, "packet state not cleared")
   `ALC_ASSERT_IMP(a_rsp_cause, clock, reset, $rose(rsp_valid_ff), $past(last_acc), "stray result")

endmodule

[test/alc_lct_header_parser_test.sv]
// ----------------------------------------------------------------------------
// ALC/LCT header parser testbench
// Streams packet bytes into the parser and checks each per-packet result
// against a byte-level parser model held here. A short table of directed
// packets comes first, then randomly built packets across several version
// register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module alc_lct_header_parser_test;
   timeunit 1ns;
   timeprecision 1ps;
   import alc_lct_pkg::*;

   typedef struct {
      logic [3:0]  err;
      logic [47:0] tsi;
      logic [63:0] toi;
      logic [7:0]  hdr_len;
      logic        close;
      logic        fti_ok;
      logic [47:0] xfer_len;
      logic [15:0] sym_len;
      logic [31:0] blk_len;
      logic        fdt_ok;
      logic [19:0] fdt_id;
      logic [1:0]  cenc;
   } hdr_result_type;

   typedef struct {
      logic [7:0]   b;
      bit           last;
      bit           typed;
      err_code_type err;
   } dir_row_type;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [1:0] paddr;
   logic [31:0] pwdata, prdata;
   logic pready;

   alc_lct_req_if req_ch ();
   alc_lct_rsp_if rsp_ch ();

   alc_lct_header_parser dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   hdr_result_type pending_hdrs[$];
   int fails = 0;
   int items_sent = 0;
   bit idling = 1;

   // parser model state
   logic [3:0]  ver_reg, ver_pkt;
   int unsigned pkt_bytes;
   logic [31:0] bw;
   int unsigned ext_left, ext_idx, ext_kind, ext_len;
   logic [47:0] tsi_acc;
   logic [63:0] toi_acc;
   logic        fti_ok, fdt_ok;
   logic [47:0] xfer_acc;
   logic [15:0] sym_acc;
   logic [31:0] blk_acc;
   logic [19:0] fdt_acc;
   logic [1:0]  cenc_acc;
   logic [3:0]  ext_err;

   // clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [63:0] shift_in(logic [63:0] acc, int pos, logic [63:0] mask,
                                           logic [7:0] b);
      logic [63:0] cur;
      cur = (acc >> pos) & mask;
      cur = ((cur << 8) | 64'(b)) & mask;
      return (acc & ~(mask << pos)) | (cur << pos);
   endfunction

   function int unsigned flag_words();
      int unsigned w;
      w = 2 + bw[27:26] + bw[20] + bw[23] + bw[22:21];
      if (ver_pkt == 4'd1) w = w + bw[19] + bw[18];
      return w;
   endfunction

   function void clear_packet();
      pkt_bytes = 0; bw = '0; ver_pkt = '0;
      ext_left = 0; ext_idx = 0; ext_kind = 0; ext_len = 0;
      tsi_acc = '0; toi_acc = '0;
      fti_ok = 0; xfer_acc = '0; sym_acc = '0; blk_acc = '0;
      fdt_ok = 0; fdt_acc = '0; cenc_acc = '0; ext_err = '0;
   endfunction

   // one byte of the extension walk
   function void walk_ext(logic [7:0] b);
      int unsigned j;
      logic [3:0] e;
      j = ext_idx;
      e = '0;
      if (j == 0) begin
         ext_kind = b;
         if (b > EXT_HEL_MAX) begin
            ext_len = 4;
            if (ext_left < 4) e = ERR_EXT_OVER;
         end else ext_len = 0;
      end else if (j == 1 && ext_kind <= EXT_HEL_MAX) begin
         ext_len = b * 4;
         if (ext_len == 0) e = ERR_EXT_ZERO;
         else if (ext_len > ext_left) e = ERR_EXT_OVER;
         else if (ext_kind == EXT_FTI) begin
            if (b != 8'd4) e = ERR_FTI_LEN;
            else fti_ok = 1;
         end
      end else if (ext_kind == EXT_FTI) begin
         if (j >= 2 && j < 4) xfer_acc = 48'(shift_in(64'(xfer_acc), 32, 64'hFFFF, b));
         else if (j >= 4 && j < 8) xfer_acc = 48'(shift_in(64'(xfer_acc), 0, 64'hFFFF_FFFF, b));
         else if (j >= 10 && j < 12) sym_acc = {sym_acc[7:0], b};
         else if (j >= 12 && j < 16) blk_acc = {blk_acc[23:0], b};
      end else if (ext_kind == EXT_FDT) begin
         if (j == 1) begin
            if (b[7:4] != ver_pkt) e = ERR_FDT_VER;
            else begin
               fdt_ok = 1;
               fdt_acc = {b[3:0], 16'h0};
            end
         end else if (j == 2) fdt_acc[15:8] = b;
         else if (j == 3) fdt_acc[7:0] = b;
      end else if (ext_kind == EXT_CONTENT_ENC) begin
         if (j == 1) begin
            if (b > 8'd3) e = ERR_ENCODING;
            else cenc_acc = b[1:0];
         end
      end
      if (e != 0) begin
         ext_err = e;
         return;
      end
      j++;
      ext_left--;
      if ((ext_kind > EXT_HEL_MAX || j >= 2) && j >= ext_len) j = 0;
      ext_idx = j & 10'h3FF;
   endfunction

   // TSI/TOI fields and extension area
   function void header_field(int unsigned p, logic [7:0] b);
      int unsigned h, s, o, pos, ow, k;
      h = bw[20]; s = bw[23]; o = bw[22:21];
      pos = 8;
      if (h && p >= pos && p < pos + 2) tsi_acc = 48'(shift_in(64'(tsi_acc), 0, 64'hFFFF, b));
      pos += 2 * h;
      if (s && p >= pos && p < pos + 4)
         tsi_acc = 48'(shift_in(64'(tsi_acc), 16 * h, 64'hFFFF_FFFF, b));
      pos += 4 * s;
      if (h && p >= pos && p < pos + 2) toi_acc = shift_in(toi_acc, 0, 64'hFFFF, b);
      pos += 2 * h;
      ow = (o == 1) ? 4 : (o == 2) ? 8 : 0;
      if (p >= pos && p < pos + ow) begin
         k = p - pos;
         toi_acc = shift_in(toi_acc, 16 * h + 32 * (k / 4), 64'hFFFF_FFFF, b);
      end
      if (p >= 4 * flag_words() && ext_left > 0 && ext_err == 0) walk_ext(b);
   endfunction

   // advance the parser by one request; returns 1 with the result on the last byte
   function bit parse_byte(logic [7:0] b, bit last, output hdr_result_type r);
      int unsigned p, hl, sw;
      logic [3:0] e;
      p = pkt_bytes;
      r = '{default: '0};
      if (p < 4) begin
         bw = {bw[23:0], b};
         if (p == 3) begin
            ver_pkt = ver_reg;
            hl = bw[15:8];
            sw = flag_words();
            ext_left = (hl >= sw) ? ((hl - sw) * 4) & 10'h3FF : 0;
            ext_idx = 0;
         end
      end else header_field(p, b);
      pkt_bytes = (p < COUNT_MAX) ? p + 1 : COUNT_MAX;
      if (!last) return 0;
      hl = bw[15:8];
      if (pkt_bytes < 4) e = ERR_SHORT;
      else if (bw[31:28] != 4'd1) e = ERR_VERSION;
      else if (hl < flag_words()) e = ERR_LEN_FLAGS;
      else if (hl * 4 > pkt_bytes) e = ERR_LEN_PKT;
      else if (bw[27:26] != 0) e = ERR_CCI;
      else if (!bw[20] && !bw[23]) e = ERR_NO_TSI;
      else if (!bw[17] && !bw[20] && bw[22:21] == 0) e = ERR_NO_TOI;
      else if ((bw[22:21] == 2 && bw[20]) || bw[22:21] == 3) e = ERR_TOI_WIDE;
      else if (bw[7:0] != 0) e = ERR_CODEPOINT;
      else e = ext_err;
      r.err = e;
      if (e == ERR_OK) begin
         r.tsi = tsi_acc; r.toi = toi_acc; r.hdr_len = hl[7:0]; r.close = bw[17];
         r.fti_ok = fti_ok; r.xfer_len = xfer_acc; r.sym_len = sym_acc; r.blk_len = blk_acc;
         r.fdt_ok = fdt_ok; r.fdt_id = fdt_acc; r.cenc = cenc_acc;
      end
      clear_packet();
      return 1;
   endfunction

   task automatic report(string what, logic [63:0] want, logic [63:0] got);
      $display("%0t ns: %s mismatch, expected %0h got %0h", $realtime, what, want, got);
      fails++;
   endtask

   // result channel: random stalls and field checks
   always @(posedge clock) begin
      hdr_result_type e;
      if (reset) rsp_ch.ready <= 1'b0;
      else begin
         rsp_ch.ready <= !idling || ($urandom_range(99) >= 27);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_hdrs.size() == 0) report("unexpected result", 0, rsp_ch.error_code);
            else begin
               e = pending_hdrs.pop_front();
               if (rsp_ch.error_code != e.err) report("error_code", e.err, rsp_ch.error_code);
               if (rsp_ch.session_id != e.tsi) report("session_id", e.tsi, rsp_ch.session_id);
               if (rsp_ch.object_id != e.toi) report("object_id", e.toi, rsp_ch.object_id);
               if (rsp_ch.header_words != e.hdr_len)
                  report("header_words", e.hdr_len, rsp_ch.header_words);
               if (rsp_ch.close_session != e.close)
                  report("close_session", e.close, rsp_ch.close_session);
               if (rsp_ch.has_fti != e.fti_ok) report("has_fti", e.fti_ok, rsp_ch.has_fti);
               if (rsp_ch.transfer_len != e.xfer_len)
                  report("transfer_len", e.xfer_len, rsp_ch.transfer_len);
               if (rsp_ch.symbol_length != e.sym_len)
                  report("symbol_length", e.sym_len, rsp_ch.symbol_length);
               if (rsp_ch.max_block_length != e.blk_len)
                  report("max_block_length", e.blk_len, rsp_ch.max_block_length);
               if (rsp_ch.has_fdt != e.fdt_ok) report("has_fdt", e.fdt_ok, rsp_ch.has_fdt);
               if (rsp_ch.fdt_instance != e.fdt_id)
                  report("fdt_instance", e.fdt_id, rsp_ch.fdt_instance);
               if (rsp_ch.content_coding != e.cenc)
                  report("content_coding", e.cenc, rsp_ch.content_coding);
            end
         end
      end
   end

   // send one request; a typed row overrides the model's result with an error result
   task automatic send_byte(logic [7:0] b, bit last, bit typed, err_code_type err);
      hdr_result_type r;
      while (idling && $urandom_range(99) < 27) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.last_byte <= last;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
      if (parse_byte(b, last, r)) begin
         if (typed) r = '{err: err, default: '0};
         pending_hdrs.push_back(r);
      end
   endtask

   task automatic send_packet(logic [7:0] pk[$]);
      foreach (pk[i]) send_byte(pk[i], i == pk.size() - 1, 0, ERR_OK);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_hdrs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_version(logic [3:0] v);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= 2'(4 * CSR_VERSION); pwdata <= 32'(v);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      ver_reg = v;
   endtask

   // build one packet: mostly well-formed with random content, some noise or damage
   task automatic make_packet(output logic [7:0] pk[$]);
      int unsigned h, s, o, a, sct, ert, sw, n, kind, hel, cut;
      logic [7:0] ext[$];
      pk = {};
      if ($urandom_range(99) < 8) begin
         n = $urandom_range(1, 40);
         repeat (n) pk.push_back(8'($urandom));
         return;
      end
      h = $urandom_range(1); s = $urandom_range(1);
      if (!h && !s) s = 1;
      o = $urandom_range(2);
      if (o == 2 && h) o = 1;
      a = $urandom_range(1);
      if (!a && !h && o == 0) o = 1;
      sct = $urandom_range(1); ert = $urandom_range(1);
      sw = 2 + s + h + o + ((ver_reg == 4'd1) ? sct + ert : 0);
      repeat ($urandom_range(0, 3)) begin
         kind = $urandom_range(4);
         case (kind)
            0: begin
               ext.push_back(EXT_FTI); ext.push_back(8'd4);
               repeat (14) ext.push_back(8'($urandom));
            end
            1: begin
               ext.push_back(EXT_FDT);
               ext.push_back({($urandom_range(9) == 0) ? 4'($urandom) : ver_reg, 4'($urandom)});
               repeat (2) ext.push_back(8'($urandom));
            end
            2: begin
               ext.push_back(EXT_CONTENT_ENC);
               ext.push_back(($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3)));
               repeat (2) ext.push_back(8'($urandom));
            end
            3: begin
               do n = $urandom_range(127); while (n == EXT_FTI);
               hel = $urandom_range(1, 3);
               ext.push_back(8'(n)); ext.push_back(8'(hel));
               repeat (hel * 4 - 2) ext.push_back(8'($urandom));
            end
            default: begin
               do n = $urandom_range(128, 255); while (n == EXT_FDT || n == EXT_CONTENT_ENC);
               ext.push_back(8'(n));
               repeat (3) ext.push_back(8'($urandom));
            end
         endcase
      end
      pk.push_back({4'd1, 2'd0, 2'($urandom)});
      pk.push_back({1'(s), 2'(o), 1'(h), 1'(sct), 1'(ert), 1'(a), 1'($urandom)});
      pk.push_back(8'(sw + ext.size() / 4));
      pk.push_back(8'd0);
      repeat (4 * sw - 4) pk.push_back(8'($urandom));
      pk = {pk, ext};
      repeat ($urandom_range(0, 8)) pk.push_back(8'($urandom));
      // damage: flip one bit or cut the packet short
      if ($urandom_range(99) < 15) begin
         if ($urandom_range(1)) begin
            n = $urandom_range(pk.size() - 1);
            pk[n][$urandom_range(7)] ^= 1'b1;
         end else begin
            cut = $urandom_range(1, pk.size());
            while (pk.size() > cut) void'(pk.pop_back());
         end
      end
   endtask

   // directed packets
   dir_row_type dir_rows[25] = '{
      '{8'hFF, 1, 1, ERR_SHORT},
      '{8'h20, 0, 0, ERR_OK}, '{8'h00, 0, 0, ERR_OK}, '{8'h01, 0, 0, ERR_OK},
      '{8'h00, 1, 1, ERR_VERSION},
      '{8'h10, 0, 0, ERR_OK}, '{8'hA2, 0, 0, ERR_OK}, '{8'h04, 0, 0, ERR_OK},
      '{8'h00, 0, 0, ERR_OK}, '{8'h00, 0, 0, ERR_OK}, '{8'h00, 0, 0, ERR_OK},
      '{8'h00, 0, 0, ERR_OK}, '{8'h00, 0, 0, ERR_OK}, '{8'hFF, 0, 0, ERR_OK},
      '{8'hFF, 0, 0, ERR_OK}, '{8'hFF, 0, 0, ERR_OK}, '{8'hFF, 1, 1, ERR_LEN_PKT},
      '{8'hFF, 0, 0, ERR_OK}, '{8'hFF, 0, 0, ERR_OK}, '{8'hFF, 0, 0, ERR_OK},
      '{8'hFF, 1, 1, ERR_VERSION},
      '{8'h00, 0, 0, ERR_OK}, '{8'h00, 0, 0, ERR_OK}, '{8'h00, 0, 0, ERR_OK},
      '{8'h00, 1, 1, ERR_VERSION}
   };

   // main sequence
   initial begin
      logic [7:0] pk[$];
      logic [3:0] phase_ver[5];
      reset <= 1'b1;
      req_ch.valid <= 1'b0; req_ch.data_byte <= '0; req_ch.last_byte <= 1'b0;
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
      ver_reg = 4'd1;
      clear_packet();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed,
                                      dir_rows[i].err);

      phase_ver = '{4'd0, 4'd15, 4'd1, 4'($urandom), 4'd1};
      for (int ph = 0; ph < 5; ph++) begin
         wait_drained();
         write_version(phase_ver[ph]);
         idling = (ph != 1);
         while (items_sent < 25 + (ph + 1) * 305) begin
            make_packet(pk);
            send_packet(pk);
            // hold the sender until the parser has drained
            if (ph == 2 && items_sent > 25 + 2 * 305 + 150 && items_sent < 25 + 2 * 305 + 200)
               wait_drained();
         end
      end
      req_ch.valid <= 1'b0;
      while (pending_hdrs.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fails == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/alc_lct_pkg.sv
src/alc_lct_req_if.sv
src/alc_lct_rsp_if.sv
src/alc_lct_header_parser.sv
test/alc_lct_header_parser_test.sv
